[sv/prav_pkg.sv]
// Shared constants, types and helpers of the per-sensor running average monitor.
package prav_pkg;

    localparam int WINDOW      = 5;
    localparam int MAX_SENSORS = 16;

    localparam int ID_W        = 16;
    localparam int TEMP_W      = 16;
    localparam int TS_W        = 32;
    localparam int STATUS_W    = 3;
    localparam int SAMPLES_W   = 5;
    localparam int CFG_INDEX_W = 2;

    localparam int IDX_W     = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int USED_W    = $clog2(MAX_SENSORS + 1);
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int WIN_DEPTH = MAX_SENSORS * WINDOW;
    localparam int WADDR_W   = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int SUM_W     = TEMP_W + $clog2(WINDOW);
    localparam int DIV_CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    localparam int IN_FIELDS_W  = 2 * ID_W + TS_W + TEMP_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * ID_W + TEMP_W + SAMPLES_W + TS_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_MAX_TEMP = cfg_index_t'(0);
    localparam cfg_index_t CFG_MIN_TEMP = cfg_index_t'(1);

    localparam logic signed [TEMP_W-1:0] MAX_TEMP_RESET = 16'sd6400;
    localparam logic signed [TEMP_W-1:0] MIN_TEMP_RESET = 16'sd3840;

    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL  = 3'd0,
        ST_HOT     = 3'd1,
        ST_COLD    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_MAPPED  = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        RES_MAP,
        RES_FULL,
        RES_UNKNOWN,
        RES_SAMPLE
    } res_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     lookup;
        logic     map_write;
        logic     sample_write;
        logic     sum_step;
        logic     div_start;
        logic     out_load;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic is_sample;
        logic hit;
        logic table_full;
        logic sum_done;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    function automatic logic [WADDR_W-1:0] win_addr(input logic [IDX_W-1:0]  idx,
                                                    input logic [SLOT_W-1:0] slot);
        return WADDR_W'(idx) * WADDR_W'(WINDOW) + WADDR_W'(slot);
    endfunction

endpackage

[sv/per_sensor_running_average_monitor_top.sv]
// Top level of the per-sensor running average monitor: controller plus datapath.
//
//  channel  | signals                               | transfer
//  ---------+---------------------------------------+------------------------------
//  s_axis   | tvalid tready tdata[79:0] tuser[0]    | one mapping or sample item
//  m_axis   | tvalid tready tdata[87:0] tuser[2:0]  | one result per item
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data| limit register write
//
// Mapping, unknown sensor and table full items pass IDLE, LOOKUP, DECIDE and RESULT, where
// the result is loaded into the output register. Sample items also pass SUM (one window read
// per sample in the average), DRAIN, DIV and DIV_WAIT; the bit-serial divider producing one
// quotient bit per cycle sets most of the wait.
// One item is in work at a time; the next is taken while a result waits in the
// output register. Reset clears the table valid bits and entry count and resets the limits.
module per_sensor_running_average_monitor_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sensor_key[15:0], room_id[31:16], timestamp[63:32], sample_value[79:64]
    input  logic [prav_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // kind[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // sensor_echo[15:0], room_out[31:16], average[47:32], samples_used[52:48],
    // last_timestamp[84:53], zero[87:85]
    output logic [prav_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [prav_pkg::STATUS_W-1:0]   m_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  prav_pkg::cfg_index_t            cfg_index,
    input  logic [prav_pkg::TEMP_W-1:0]     cfg_data
);

    prav_pkg::dp_cmd_t  cmd;
    prav_pkg::dp_stat_t stat;

    prav_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    prav_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

endmodule

[sv/prav_div.sv]
// Bit-serial signed divider: one quotient bit per cycle, result truncated toward zero.
module prav_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [prav_pkg::SUM_W-1:0] dividend,
    input  logic [prav_pkg::FILL_W-1:0]       divisor,
    output logic                              done,
    output logic signed [prav_pkg::TEMP_W-1:0] quotient
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [prav_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic                              neg_reg;
    logic [prav_pkg::FILL_W-1:0]       dvs_reg;
    logic [prav_pkg::FILL_W-1:0]       rem_reg;
    logic [prav_pkg::SUM_W-1:0]        quo_reg;

    logic [prav_pkg::FILL_W:0]         rem_shift;
    logic                              take;
    logic [prav_pkg::FILL_W:0]         rem_sub;
    logic [prav_pkg::FILL_W-1:0]       rem_next;
    logic [prav_pkg::TEMP_W-1:0]       mag;

    assign rem_shift = {rem_reg, quo_reg[prav_pkg::SUM_W-1]};
    assign take      = (rem_shift >= {1'b0, dvs_reg});
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};
    assign rem_next  = take ? rem_sub[prav_pkg::FILL_W-1:0] : rem_shift[prav_pkg::FILL_W-1:0];
    assign mag       = quo_reg[prav_pkg::TEMP_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + prav_pkg::DIV_CNT_W'(1);
                if (cnt_reg == prav_pkg::DIV_CNT_W'(prav_pkg::SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[prav_pkg::SUM_W-1];
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend[prav_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[prav_pkg::SUM_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag) : $signed(mag);

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

[sv/prav_datapath.sv]
// Datapath: item and limit registers, sensor table, sample window memory, sum, divide, result.
module prav_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  prav_pkg::dp_cmd_t                   cmd,
    output prav_pkg::dp_stat_t                  stat,
    input  logic [prav_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [prav_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [prav_pkg::STATUS_W-1:0]       m_axis_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  prav_pkg::cfg_index_t                cfg_index,
    input  logic [prav_pkg::TEMP_W-1:0]         cfg_data
);

    localparam int ROOM_LO = prav_pkg::ID_W;
    localparam int TS_LO   = 2 * prav_pkg::ID_W;
    localparam int VAL_LO  = 2 * prav_pkg::ID_W + prav_pkg::TS_W;

    logic signed [prav_pkg::TEMP_W-1:0] max_temp_reg;
    logic signed [prav_pkg::TEMP_W-1:0] min_temp_reg;

    logic                               kind_reg;
    logic [prav_pkg::ID_W-1:0]          sid_reg;
    logic [prav_pkg::ID_W-1:0]          room_reg;
    logic [prav_pkg::TS_W-1:0]          ts_reg;
    logic signed [prav_pkg::TEMP_W-1:0] val_reg;

    logic                               ent_valid_reg  [prav_pkg::MAX_SENSORS];
    logic [prav_pkg::ID_W-1:0]          ent_sensor_reg [prav_pkg::MAX_SENSORS];
    logic [prav_pkg::ID_W-1:0]          ent_room_reg   [prav_pkg::MAX_SENSORS];
    logic [prav_pkg::FILL_W-1:0]        ent_fill_reg   [prav_pkg::MAX_SENSORS];
    logic [prav_pkg::SLOT_W-1:0]        ent_head_reg   [prav_pkg::MAX_SENSORS];
    logic [prav_pkg::USED_W-1:0]        used_reg;

    logic                               hit_any;
    logic [prav_pkg::IDX_W-1:0]         hit_idx;
    logic                               hit_reg;
    logic [prav_pkg::IDX_W-1:0]         hit_idx_reg;
    logic [prav_pkg::IDX_W-1:0]         map_idx;
    logic                               table_full;

    logic signed [prav_pkg::TEMP_W-1:0] win_mem [prav_pkg::WIN_DEPTH];
    logic signed [prav_pkg::TEMP_W-1:0] win_q_reg;

    logic [prav_pkg::SLOT_W-1:0]        slot_cur;
    logic [prav_pkg::FILL_W-1:0]        fill_cur;
    logic [prav_pkg::FILL_W-1:0]        fill_new;
    logic [prav_pkg::SLOT_W-1:0]        rd_slot_reg;
    logic [prav_pkg::FILL_W-1:0]        rem_reg;
    logic [prav_pkg::FILL_W-1:0]        n_reg;
    logic                               rd_pend_reg;
    logic signed [prav_pkg::SUM_W-1:0]  acc_reg;

    logic                               div_done;
    logic signed [prav_pkg::TEMP_W-1:0] div_quotient;
    logic signed [prav_pkg::TEMP_W-1:0] avg_reg;

    prav_pkg::status_t                  res_status;
    logic [prav_pkg::ID_W-1:0]          res_room;
    logic signed [prav_pkg::TEMP_W-1:0] res_avg;
    logic [prav_pkg::SAMPLES_W-1:0]     res_used;
    logic [prav_pkg::TS_W-1:0]          res_ts;

    logic                               out_valid_reg;
    prav_pkg::status_t                  out_status_reg;
    logic [prav_pkg::OUT_DATA_W-1:0]    out_data_reg;

    function automatic logic [prav_pkg::SLOT_W-1:0] slot_inc(
        input logic [prav_pkg::SLOT_W-1:0] s);
        return (s == prav_pkg::SLOT_W'(prav_pkg::WINDOW - 1)) ? '0
                                                               : s + prav_pkg::SLOT_W'(1);
    endfunction

    function automatic logic [prav_pkg::SLOT_W-1:0] slot_dec(
        input logic [prav_pkg::SLOT_W-1:0] s);
        return (s == '0) ? prav_pkg::SLOT_W'(prav_pkg::WINDOW - 1)
                         : s - prav_pkg::SLOT_W'(1);
    endfunction

    // limit registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_temp_reg <= prav_pkg::MAX_TEMP_RESET;
            min_temp_reg <= prav_pkg::MIN_TEMP_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                prav_pkg::CFG_MAX_TEMP: max_temp_reg <= cfg_data;
                prav_pkg::CFG_MIN_TEMP: min_temp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg <= s_axis_tuser;
            sid_reg  <= s_axis_tdata[prav_pkg::ID_W-1:0];
            room_reg <= s_axis_tdata[ROOM_LO +: prav_pkg::ID_W];
            ts_reg   <= s_axis_tdata[TS_LO +: prav_pkg::TS_W];
            val_reg  <= s_axis_tdata[VAL_LO +: prav_pkg::TEMP_W];
        end
    end

    // table match, lowest index wins
    always_comb
    begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int i = prav_pkg::MAX_SENSORS - 1; i >= 0; i--)
        begin
            if (ent_valid_reg[i] && ent_sensor_reg[i] == sid_reg)
            begin
                hit_any = 1'b1;
                hit_idx = prav_pkg::IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg     <= hit_any;
            hit_idx_reg <= hit_idx;
        end
    end

    assign table_full = (used_reg == prav_pkg::USED_W'(prav_pkg::MAX_SENSORS));
    assign map_idx    = hit_reg ? hit_idx_reg : used_reg[prav_pkg::IDX_W-1:0];
    assign slot_cur   = ent_head_reg[hit_idx_reg];
    assign fill_cur   = ent_fill_reg[hit_idx_reg];
    assign fill_new   = (fill_cur == prav_pkg::FILL_W'(prav_pkg::WINDOW))
                        ? fill_cur : fill_cur + prav_pkg::FILL_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < prav_pkg::MAX_SENSORS; i++)
            begin
                ent_valid_reg[i] <= 1'b0;
            end
            used_reg <= '0;
        end
        else if (cmd.map_write)
        begin
            ent_valid_reg[map_idx] <= 1'b1;
            if (!hit_reg)
            begin
                used_reg <= used_reg + prav_pkg::USED_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.map_write)
        begin
            ent_sensor_reg[map_idx] <= sid_reg;
            ent_room_reg[map_idx]   <= room_reg;
            ent_fill_reg[map_idx]   <= '0;
            ent_head_reg[map_idx]   <= '0;
        end
        else if (cmd.sample_write)
        begin
            ent_fill_reg[hit_idx_reg] <= fill_new;
            ent_head_reg[hit_idx_reg] <= slot_inc(slot_cur);
        end
    end

    // sample window: newest written at head, summed newest to oldest
    always_ff @(posedge clk)
    begin
        if (cmd.sample_write)
        begin
            win_mem[prav_pkg::win_addr(hit_idx_reg, slot_cur)] <= val_reg;
        end
        if (cmd.sum_step)
        begin
            win_q_reg <= win_mem[prav_pkg::win_addr(hit_idx_reg, rd_slot_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            rem_reg     <= '0;
        end
        else
        begin
            rd_pend_reg <= cmd.sum_step;
            if (cmd.sample_write)
            begin
                rem_reg <= fill_new;
            end
            else if (cmd.sum_step)
            begin
                rem_reg <= rem_reg - prav_pkg::FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sample_write)
        begin
            rd_slot_reg <= slot_cur;
            n_reg       <= fill_new;
            acc_reg     <= '0;
        end
        else
        begin
            if (cmd.sum_step)
            begin
                rd_slot_reg <= slot_dec(rd_slot_reg);
            end
            if (rd_pend_reg)
            begin
                acc_reg <= acc_reg + prav_pkg::SUM_W'(win_q_reg);
            end
        end
        if (div_done)
        begin
            avg_reg <= div_quotient;
        end
    end

    prav_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (n_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // result forming
    always_comb
    begin
        res_status = prav_pkg::ST_UNKNOWN;
        res_room   = '0;
        res_avg    = '0;
        res_used   = '0;
        res_ts     = '0;
        unique case (cmd.res_sel)
            prav_pkg::RES_MAP:
            begin
                res_status = prav_pkg::ST_MAPPED;
                res_room   = room_reg;
            end
            prav_pkg::RES_FULL:
            begin
                res_status = prav_pkg::ST_FULL;
            end
            prav_pkg::RES_UNKNOWN:
            begin
                res_status = prav_pkg::ST_UNKNOWN;
            end
            prav_pkg::RES_SAMPLE:
            begin
                priority if (avg_reg > max_temp_reg)
                begin
                    res_status = prav_pkg::ST_HOT;
                end
                else if (avg_reg < min_temp_reg)
                begin
                    res_status = prav_pkg::ST_COLD;
                end
                else
                begin
                    res_status = prav_pkg::ST_NORMAL;
                end
                res_room = ent_room_reg[hit_idx_reg];
                res_avg  = avg_reg;
                res_used = prav_pkg::SAMPLES_W'(n_reg);
                res_ts   = ts_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= res_status;
            out_data_reg   <= prav_pkg::OUT_DATA_W'({res_ts, res_used, res_avg,
                                                     res_room, sid_reg});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    assign stat.is_sample  = kind_reg;
    assign stat.hit        = hit_reg;
    assign stat.table_full = table_full;
    assign stat.sum_done   = (rem_reg == '0);
    assign stat.div_done   = div_done;
    assign stat.out_free   = !out_valid_reg || m_axis_tready;

    a_map_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.map_write |-> (hit_reg || !table_full))
        else $error("mapping written into a full table");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= prav_pkg::USED_W'(prav_pkg::MAX_SENSORS))
        else $error("entry count beyond table size");

    a_sample_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sample_write |-> (hit_reg && ent_valid_reg[hit_idx_reg]))
        else $error("sample written for an unmapped entry");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("pending result overwritten");

endmodule

[sv/prav_ctrl.sv]
// Controller state machine sequencing lookup, table update, window sum, divide and result.
module prav_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  prav_pkg::dp_stat_t stat,
    output prav_pkg::dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_SUM,
        S_DRAIN,
        S_DIV,
        S_DIV_WAIT,
        S_RESULT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    prav_pkg::res_sel_t res_sel_reg;
    prav_pkg::res_sel_t res_sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            res_sel_reg <= prav_pkg::RES_UNKNOWN;
        end
        else
        begin
            state_reg   <= state_next;
            res_sel_reg <= res_sel_next;
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.res_sel   = res_sel_reg;
        state_next    = state_reg;
        res_sel_next  = res_sel_reg;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!stat.is_sample)
                begin
                    if (stat.hit || !stat.table_full)
                    begin
                        cmd.map_write = 1'b1;
                        res_sel_next  = prav_pkg::RES_MAP;
                    end
                    else
                    begin
                        res_sel_next = prav_pkg::RES_FULL;
                    end
                    state_next = S_RESULT;
                end
                else if (stat.hit)
                begin
                    cmd.sample_write = 1'b1;
                    state_next       = S_SUM;
                end
                else
                begin
                    res_sel_next = prav_pkg::RES_UNKNOWN;
                    state_next   = S_RESULT;
                end
            end
            S_SUM:
            begin
                if (stat.sum_done)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cmd.sum_step = 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    res_sel_next = prav_pkg::RES_SAMPLE;
                    state_next   = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

endmodule
